// File: hdl/bal_pkg.sv
// Shared constants and types for the battery average low alarm block.
package bal_pkg;

    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int MV_BITS    = 14;
    localparam int SCALE_BITS = 16;
    localparam int SCALE_FRAC = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [MV_BITS-1:0]    MV_MAX         = 14'd16383;
    localparam logic [MV_BITS-1:0]    THRESHOLD_RST  = 14'd8000;
    localparam logic [MV_BITS-1:0]    HYSTERESIS_RST = 14'd1000;
    localparam logic [SCALE_BITS-1:0] SCALE_RST      = 16'd24842;

    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HYSTERESIS    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCALE         = 2'd2;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SET   = 2'd1,
        EVT_CLEAR = 2'd2
    } event_t;

endpackage

// File: hdl/battery_average_low_alarm_core.sv
// Top level of the battery average low alarm: configuration registers and stage chain.
//
// Takes one converter word per cycle and returns one result word per cycle after the
// first. The first word after reset primes the averaging window and gives no result.
// Each accepted word passes in order: the window sum update registers at the
// accepting edge, then the Q16 scale multiply, then saturation and alarm compare,
// each ending in a register.
// Backpressure on the result side stalls the chain stage by stage; the input keeps
// accepting while any stage has room. Write the configuration registers only while
// the block is idle.
module battery_average_low_alarm_core import bal_pkg::*; #(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [SAMPLE_BITS-1:0]   s_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [MV_BITS-1:0]       m_voltage_mv,
    output logic                     m_alarm,
    output logic [1:0]               m_event_res
);

    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
    localparam int PROD_BITS = SUM_BITS + SCALE_BITS;

    logic [MV_BITS-1:0]    threshold_reg;
    logic [MV_BITS-1:0]    hysteresis_reg;
    logic [SCALE_BITS-1:0] scale_reg;
    logic [MV_BITS:0]      clear_limit;

    logic                  sum_valid, sum_ready;
    logic [SUM_BITS-1:0]   sum_value;
    logic                  prod_valid, prod_ready;
    logic [PROD_BITS-1:0]  prod_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RST;
            hysteresis_reg <= HYSTERESIS_RST;
            scale_reg      <= SCALE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOW_THRESHOLD: threshold_reg  <= cfg_wdata[MV_BITS-1:0];
                REG_HYSTERESIS:    hysteresis_reg <= cfg_wdata[MV_BITS-1:0];
                REG_SCALE:         scale_reg      <= cfg_wdata[SCALE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign clear_limit = {1'b0, threshold_reg} + {1'b0, hysteresis_reg};

    bal_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_sample  (s_sample),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_value (sum_value)
    );

    bal_scale #(
        .SUM_BITS (SUM_BITS)
    ) u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .scale_q16  (scale_reg),
        .sum_valid  (sum_valid),
        .sum_ready  (sum_ready),
        .sum_value  (sum_value),
        .prod_valid (prod_valid),
        .prod_ready (prod_ready),
        .prod_value (prod_value)
    );

    bal_alarm #(
        .PROD_BITS (PROD_BITS)
    ) u_alarm (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .low_threshold_mv (threshold_reg),
        .clear_limit      (clear_limit),
        .prod_valid       (prod_valid),
        .prod_ready       (prod_ready),
        .prod_value       (prod_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_voltage_mv     (m_voltage_mv),
        .m_alarm          (m_alarm),
        .m_event_res      (m_event_res)
    );

endmodule

// File: hdl/bal_window.sv
// Sample window: shift line of recent samples, running sum and priming.
module bal_window import bal_pkg::*; #(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    output logic                   sum_valid,
    input  logic                   sum_ready,
    output logic [SUM_BITS-1:0]    sum_value
);

    logic [SAMPLE_BITS-1:0] ring_reg [WINDOW];
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic                   primed_reg;
    logic                   valid_reg, valid_next;
    logic                   accept;

    assign s_ready   = !valid_reg || sum_ready;
    assign accept    = s_valid && s_ready;
    assign sum_valid = valid_reg;
    assign sum_value = sum_reg;

    always_comb begin
        if (primed_reg) begin
            sum_next = sum_reg - SUM_BITS'(ring_reg[WINDOW-1]) + SUM_BITS'(s_sample);
        end else begin
            sum_next = SUM_BITS'(s_sample) * SUM_BITS'(WINDOW);
        end
        if (accept) begin
            valid_next = primed_reg;
        end else begin
            valid_next = valid_reg && !sum_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg    <= '0;
            primed_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                sum_reg    <= sum_next;
                primed_reg <= 1'b1;
            end
        end
    end

    // fill every slot on the priming word, otherwise advance the line
    always_ff @(posedge aclk) begin
        if (accept) begin
            ring_reg[0] <= s_sample;
            for (int i = 1; i < WINDOW; i++) begin
                ring_reg[i] <= primed_reg ? ring_reg[i-1] : s_sample;
            end
        end
    end

endmodule

// File: hdl/bal_scale.sv
// Scale stage: multiply the window sum by the Q16 millivolt factor.
module bal_scale import bal_pkg::*; #(
    parameter int SUM_BITS   = SAMPLE_BITS_DEF + $clog2(WINDOW_DEF),
    localparam int PROD_BITS = SUM_BITS + SCALE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [SCALE_BITS-1:0] scale_q16,
    input  logic                  sum_valid,
    output logic                  sum_ready,
    input  logic [SUM_BITS-1:0]   sum_value,
    output logic                  prod_valid,
    input  logic                  prod_ready,
    output logic [PROD_BITS-1:0]  prod_value
);

    logic [PROD_BITS-1:0] prod_reg;
    logic                 valid_reg;
    logic                 accept;

    assign sum_ready  = !valid_reg || prod_ready;
    assign accept     = sum_valid && sum_ready;
    assign prod_valid = valid_reg;
    assign prod_value = prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (sum_ready) begin
            valid_reg <= sum_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prod_reg <= PROD_BITS'(sum_value) * PROD_BITS'(scale_q16);
        end
    end

endmodule

// File: hdl/bal_alarm.sv
// Result stage: saturate to millivolts, run the hysteresis alarm, hold the result word.
module bal_alarm import bal_pkg::*; #(
    parameter int PROD_BITS = SAMPLE_BITS_DEF + $clog2(WINDOW_DEF) + SCALE_BITS,
    localparam int HI_BITS  = PROD_BITS - SCALE_FRAC,
    localparam int CMP_BITS = HI_BITS + MV_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [MV_BITS-1:0]   low_threshold_mv,
    input  logic [MV_BITS:0]     clear_limit,
    input  logic                 prod_valid,
    output logic                 prod_ready,
    input  logic [PROD_BITS-1:0] prod_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MV_BITS-1:0]   m_voltage_mv,
    output logic                 m_alarm,
    output logic [1:0]           m_event_res
);

    logic [MV_BITS-1:0] mv_reg, mv_next;
    logic               alarm_reg, alarm_next;
    event_t             event_reg, event_next;
    logic               valid_reg;
    logic               accept;
    logic [HI_BITS-1:0] hi;

    assign prod_ready   = !valid_reg || m_ready;
    assign accept       = prod_valid && prod_ready;
    assign m_valid      = valid_reg;
    assign m_voltage_mv = mv_reg;
    assign m_alarm      = alarm_reg;
    assign m_event_res  = event_reg;
    assign hi           = prod_value[PROD_BITS-1:SCALE_FRAC];

    always_comb begin
        if (CMP_BITS'(hi) > CMP_BITS'(MV_MAX)) begin
            mv_next = MV_MAX;
        end else begin
            mv_next = MV_BITS'(hi);
        end
        alarm_next = alarm_reg;
        event_next = EVT_NONE;
        if (mv_next < low_threshold_mv && !alarm_reg) begin
            alarm_next = 1'b1;
            event_next = EVT_SET;
        end else if ({1'b0, mv_next} > clear_limit && alarm_reg) begin
            alarm_next = 1'b0;
            event_next = EVT_CLEAR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            alarm_reg <= 1'b0;
        end else begin
            if (prod_ready) begin
                valid_reg <= prod_valid;
            end
            if (accept) begin
                alarm_reg <= alarm_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mv_reg    <= mv_next;
            event_reg <= event_next;
        end
    end

endmodule

// File: verif/battery_average_low_alarm_core_test.sv
// Self-checking testbench for battery_average_low_alarm_core: directed and random samples.
module battery_average_low_alarm_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bal_pkg::*;

    localparam int          SETTLE      = 8;
    localparam int          LONG_HOLD   = 80;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 200;
    localparam int          MAX_PRINTS  = 40;
    localparam logic [1:0]  REG_SPARE   = 2'd3;

    typedef struct packed {
        logic [MV_BITS-1:0] mv;
        logic               alarm;
        event_t             evt;
    } reading_t;

    class alarm_scoreboard;
        logic [MV_BITS-1:0]          thr;
        logic [MV_BITS-1:0]          hys;
        logic [SCALE_BITS-1:0]       scale;
        logic [SAMPLE_BITS_DEF-1:0]  ring [WINDOW_DEF];
        int                          slot;
        logic [15:0]                 sum;
        bit                          primed;
        bit                          latched;
        reading_t                    readings_due [$];
        int errors, samples, results, sets, clears, saturated;

        function new();
            thr = THRESHOLD_RST;
            hys = HYSTERESIS_RST;
            scale = SCALE_RST;
            slot = 0;
            sum = '0;
            primed = 0;
            latched = 0;
            errors = 0;
            samples = 0;
            results = 0;
            sets = 0;
            clears = 0;
            saturated = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                REG_LOW_THRESHOLD: thr = data[MV_BITS-1:0];
                REG_HYSTERESIS:    hys = data[MV_BITS-1:0];
                REG_SCALE:         scale = data[SCALE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SAMPLE_BITS_DEF-1:0] s);
            int          i;
            logic [31:0] prod;
            logic [15:0] avg;
            logic [14:0] clear_lim;
            reading_t    r;
            samples++;
            if (!primed) begin
                for (i = 0; i < WINDOW_DEF; i++) ring[i] = s;
                sum = 16'(s) * 16'(WINDOW_DEF);
                slot = 0;
                primed = 1;
                return;
            end
            sum = sum - 16'(ring[slot]) + 16'(s);
            ring[slot] = s;
            slot = (slot + 1 == WINDOW_DEF) ? 0 : slot + 1;
            prod = 32'(sum) * 32'(scale);
            avg = prod[31:16];
            r.mv = (avg > 16'(MV_MAX)) ? MV_MAX : avg[MV_BITS-1:0];
            r.evt = EVT_NONE;
            clear_lim = 15'(thr) + 15'(hys);
            if (r.mv < thr && !latched) begin
                latched = 1;
                r.evt = EVT_SET;
            end else if (15'(r.mv) > clear_lim && latched) begin
                latched = 0;
                r.evt = EVT_CLEAR;
            end
            r.alarm = latched;
            readings_due.push_back(r);
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        task report(input string what);
            if (errors < MAX_PRINTS) $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [MV_BITS-1:0] mv, logic alarm, logic [1:0] evt);
            reading_t want;
            if (readings_due.size() == 0) begin
                report($sformatf("unexpected word mv=%0d alarm=%0b event=%0d", mv, alarm, evt));
                return;
            end
            want = readings_due.pop_front();
            results++;
            if (mv !== want.mv)
                report($sformatf("word %0d voltage_mv %0d, want %0d", results, mv, want.mv));
            if (alarm !== want.alarm)
                report($sformatf("word %0d alarm %0b, want %0b", results, alarm, want.alarm));
            if (evt !== want.evt)
                report($sformatf("word %0d event %0d, want %0d", results, evt, want.evt));
            if (want.evt == EVT_SET) sets++;
            if (want.evt == EVT_CLEAR) clears++;
            if (want.mv == MV_MAX) saturated++;
        endtask
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CFG_IDX_BITS-1:0]    cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata;
    logic                       s_valid;
    logic                       s_ready;
    logic [SAMPLE_BITS_DEF-1:0] s_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic [MV_BITS-1:0]         m_voltage_mv;
    logic                       m_alarm;
    logic [1:0]                 m_event_res;

    bit              calm;
    bit              hold_req;
    int              settings;
    alarm_scoreboard sb;

    battery_average_low_alarm_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_voltage_mv (m_voltage_mv),
        .m_alarm      (m_alarm),
        .m_event_res  (m_event_res)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task cfg_write(input logic [1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task set_regs(input logic [15:0] thr, input logic [15:0] hys, input logic [15:0] scale);
        cfg_write(REG_LOW_THRESHOLD, thr);
        cfg_write(REG_HYSTERESIS, hys);
        cfg_write(REG_SCALE, scale);
        cfg_write(REG_SPARE, 16'($urandom_range(0, 65535)));
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    task send_sample(input logic [SAMPLE_BITS_DEF-1:0] smp);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(smp);
    endtask

    task wait_for_readings();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // result side
    initial begin
        int gap;
        m_ready = 1'b0;
        gap = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_voltage_mv, m_alarm, m_event_res);
                gap = calm ? 0 : $urandom_range(0, 11);
            end
            if (hold_req) begin
                hold_req = 0;
                gap = LONG_HOLD;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                gap--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        logic [SAMPLE_BITS_DEF-1:0] opening [25];
        logic [SAMPLE_BITS_DEF-1:0] smp;
        int  n, p, mode, level, step;
        bit  rising;

        opening = '{12'hFFF, 12'hFFF, 12'hFFF,
                    12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                    12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
                    12'hAAA, 12'h555,
                    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
                    12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF};
        sb = new();
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_sample  = '0;
        calm      = 0;
        hold_req  = 0;
        settings  = 1;
        mode      = 0;
        level     = $urandom_range(0, 4095);
        rising    = 1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // prime at full scale, drop to set, then recover to clear under reset values
        for (n = 0; n < 25; n++) send_sample(opening[n]);
        wait_for_readings();

        // saturation with a clear limit out of reach
        set_regs(16'h3FFF, 16'h3FFF, 16'hFFFF);
        for (n = 0; n < 22; n++) send_sample((n >= 8 && n < 12) ? 12'h000 : 12'hFFF);
        wait_for_readings();

        set_regs(16'h0000, 16'h0000, 16'h0000);
        for (n = 0; n < 6; n++) send_sample(12'($urandom_range(0, 4095)));
        wait_for_readings();

        for (p = 0; p < PHASES; p++) begin
            if (p % 3 == 0)
                set_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
            else
                set_regs(16'($urandom_range(6000, 10000)), 16'($urandom_range(0, 2000)),
                         16'($urandom_range(20000, 30000)));
            calm = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                calm = 1;
                hold_req = 1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0) mode = $urandom_range(0, 3);
                if (mode == 0) begin
                    smp = ($urandom_range(0, 7) == 0) ? {SAMPLE_BITS_DEF{rising}}
                                                      : 12'($urandom_range(0, 4095));
                end else begin
                    step = $urandom_range(0, 48);
                    level = rising ? level + step : level - step;
                    if (level > 4095) begin
                        level = 4095;
                        rising = 0;
                    end
                    if (level < 0) begin
                        level = 0;
                        rising = 1;
                    end
                    if ($urandom_range(0, 15) == 0) rising = !rising;
                    smp = 12'(level);
                end
                send_sample(smp);
            end
            wait_for_readings();
        end

        $display("Ran %0d samples under %0d register settings, %0d result words checked.",
                 sb.samples, settings, sb.results);
        $display("Alarm set %0d times, cleared %0d times, %0d saturated readings.",
                 sb.sets, sb.clears, sb.saturated);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
